[hdl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int REGION_BYTES = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_W       = $clog2(REGION_BYTES);
    localparam int SIZE_W       = 11;
    localparam int LINK_W       = 11;

    // all-ones link marks the end of a list
    localparam logic [LINK_W-1:0] NULL_LINK = '1;
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(REGION_BYTES - HEADER_BYTES);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] next;
    } hdr_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        hdr_t              wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_offset;
        logic [SIZE_W-1:0] granted_size;
    } result_t;

endpackage

[hdl/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first-fit allocator over a 1 KiB region with free and used block lists
// ----------------------------------------------------------------------------
// usage:
//   slave channel (s_*) takes one request beat: tuser selects allocate (0) or
//   free (1), tdata carries the request size and the payload offset to free.
//   master channel (m_*) returns exactly one result beat per request.
//   one request is in flight at a time; s_tready is high only while idle.
//   sequence: the first header read is issued when a request is accepted,
//   then one list link is visited per cycle (the single read port of the
//   header store sets this pace), then the write states WR1, WR2 and WR3
//   do split, unlink and push (a free skips WR1), and the result is then
//   registered into the output register; the walk is at most about 64 links
//   for a 1 KiB region with 16 byte headers. requests that end before any
//   read (empty list, short free, null free with status OK) skip the walk.
//   after reset the whole region is one free block at offset 0 and the used
//   list is empty; no clearing pass is needed.
//   when m_tready is low the result beat waits in the output register and
//   the block stalls in its result state until the register frees up.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // request_size[10:0], payload_offset[20:11], zero pad
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], granted_offset[11:2], granted_size[22:12]
);
    import ffha_pkg::*;

    mem_req_t mem_req;
    hdr_t     mem_rd;
    result_t  res;
    logic     res_valid;
    logic     res_free;

    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg, out_data_next;

    // output register frees up in the same cycle its beat is taken
    assign res_free = !out_valid_reg || m_tready;

    ffha_hdr_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    ffha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_req    (s_tdata[10:0]),
        .in_pay    (s_tdata[20:11]),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.granted_size, out_data_reg.granted_offset,
                       out_data_reg.status};

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !res_valid)
        else $error("result overwrote a waiting beat");

    a_busy_while_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> !s_tready || m_tvalid)
        else $error("result lost after handoff");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_NO_FIT
                      || m_tdata[1:0] == ST_NOT_FOUND))
        else $error("bad status code");

endmodule

[hdl/ffha_hdr_mem.sv]
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// header store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ffha_hdr_mem (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffha_pkg::mem_req_t req,
    output ffha_pkg::hdr_t    rd_data
);
    import ffha_pkg::*;

    hdr_t              mem [REGION_BYTES];
    hdr_t              q_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic              init0_reg;
    logic              init0_next;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg     <= mem[req.rd_addr];
            raddr_reg <= req.rd_addr;
        end
    end

    // entry 0 reads as the whole region until first written
    always_comb begin
        init0_next = init0_reg;
        if (req.wr_en && req.wr_addr == '0) begin
            init0_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init0_reg <= 1'b1;
        end else begin
            init0_reg <= init0_next;
        end
    end

    always_comb begin
        if (init0_reg && raddr_reg == '0) begin
            rd_data.size = INIT_SIZE;
            rd_data.next = NULL_LINK;
        end else begin
            rd_data = q_reg;
        end
    end

endmodule

[hdl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// list walk and relink sequencer around the header store
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic [ffha_pkg::SIZE_W-1:0]  in_req,
    input  logic [ffha_pkg::ADDR_W-1:0]  in_pay,
    output ffha_pkg::mem_req_t           mem_req,
    input  ffha_pkg::hdr_t               mem_rd,
    input  logic                         res_free,
    output logic                         res_valid,
    output ffha_pkg::result_t            res
);
    import ffha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_WR1  = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_WR3  = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              action_reg, action_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic              pvld_reg, pvld_next;
    logic [SIZE_W-1:0] psize_reg, psize_next;
    logic [SIZE_W-1:0] csize_reg, csize_next;
    logic [LINK_W-1:0] after_reg, after_next;
    logic              split_reg, split_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] fhead_reg, fhead_next;
    logic [LINK_W-1:0] uhead_reg, uhead_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              fits;
    logic [11:0]       tail_sum;
    logic [11:0]       need;
    logic [SIZE_W-1:0] excess;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_RESP) && res_free;
    assign res       = res_reg;

    assign fits     = {1'b0, mem_rd.size} >= {1'b0, req_reg};
    assign need     = {1'b0, req_reg} + 12'(HEADER_BYTES);
    assign tail_sum = {2'b0, cur_reg} + need;
    assign excess   = csize_reg - req_reg - SIZE_W'(HEADER_BYTES);

    always_comb begin
        state_next  = state_reg;
        action_next = action_reg;
        req_next    = req_reg;
        target_next = target_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        pvld_next   = pvld_reg;
        psize_next  = psize_reg;
        csize_next  = csize_reg;
        after_next  = after_reg;
        split_next  = split_reg;
        tail_next   = tail_reg;
        fhead_next  = fhead_reg;
        uhead_next  = uhead_reg;
        res_next    = res_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    action_next = in_action;
                    req_next    = in_req;
                    target_next = in_pay - ADDR_W'(HEADER_BYTES);
                    pvld_next   = 1'b0;
                    res_next    = '0;
                    if (in_action == ACT_ALLOC) begin
                        if (fhead_reg[LINK_W-1]) begin
                            res_next.status = ST_NO_FIT;
                            state_next      = S_RESP;
                        end else begin
                            cur_next        = fhead_reg[ADDR_W-1:0];
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = fhead_reg[ADDR_W-1:0];
                            state_next      = S_WALK;
                        end
                    end else if (in_pay == '0) begin
                        state_next = S_RESP;
                    end else if (in_pay < ADDR_W'(HEADER_BYTES) || uhead_reg[LINK_W-1]) begin
                        res_next.status = ST_NOT_FOUND;
                        state_next      = S_RESP;
                    end else begin
                        cur_next        = uhead_reg[ADDR_W-1:0];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = uhead_reg[ADDR_W-1:0];
                        state_next      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                csize_next = mem_rd.size;
                if (action_reg == ACT_ALLOC && fits) begin
                    split_next = ({1'b0, mem_rd.size} > need) && !tail_sum[11]
                                 && !tail_sum[10];
                    tail_next  = tail_sum[ADDR_W-1:0];
                    after_next = split_next ? {1'b0, tail_sum[ADDR_W-1:0]} : mem_rd.next;
                    state_next = S_WR1;
                end else if (action_reg == ACT_FREE && cur_reg == target_reg) begin
                    after_next = mem_rd.next;
                    state_next = S_WR2;
                end else if (mem_rd.next[LINK_W-1] || mem_rd.next[ADDR_W]) begin
                    res_next.status = (action_reg == ACT_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    state_next      = S_RESP;
                end else begin
                    // one link per cycle: next address comes straight from read data
                    prev_next       = cur_reg;
                    pvld_next       = 1'b1;
                    psize_next      = mem_rd.size;
                    cur_next        = mem_rd.next[ADDR_W-1:0];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rd.next[ADDR_W-1:0];
                end
            end
            S_WR1: begin
                // split tail becomes a new free block
                if (split_reg) begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = tail_reg;
                    mem_req.wr_data.size = excess;
                    mem_req.wr_data.next = (action_reg == ACT_ALLOC) ? mem_rd.next : after_reg;
                end
                state_next = S_WR2;
            end
            S_WR2: begin
                // unlink from current list
                if (pvld_reg) begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = prev_reg;
                    mem_req.wr_data.size = psize_reg;
                    mem_req.wr_data.next = after_reg;
                end else if (action_reg == ACT_ALLOC) begin
                    fhead_next = after_reg;
                end else begin
                    uhead_next = after_reg;
                end
                state_next = S_WR3;
            end
            S_WR3: begin
                // push onto head of the other list
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                if (action_reg == ACT_ALLOC) begin
                    mem_req.wr_data.size = split_reg ? req_reg : csize_reg;
                    mem_req.wr_data.next = uhead_reg;
                    uhead_next           = {1'b0, cur_reg};
                    res_next.status         = ST_OK;
                    res_next.granted_offset = cur_reg + ADDR_W'(HEADER_BYTES);
                    res_next.granted_size   = split_reg ? req_reg : csize_reg;
                end else begin
                    mem_req.wr_data.size = csize_reg;
                    mem_req.wr_data.next = fhead_reg;
                    fhead_next           = {1'b0, cur_reg};
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fhead_reg <= '0;
            uhead_reg <= NULL_LINK;
        end else begin
            state_reg <= state_next;
            fhead_reg <= fhead_next;
            uhead_reg <= uhead_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        req_reg    <= req_next;
        target_reg <= target_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        pvld_reg   <= pvld_next;
        psize_reg  <= psize_next;
        csize_reg  <= csize_next;
        after_reg  <= after_next;
        split_reg  <= split_next;
        tail_reg   <= tail_next;
        res_reg    <= res_next;
    end

    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("header store read and write in one cycle");

    a_wr_only_in_relink: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == S_WR1 || state_reg == S_WR2 || state_reg == S_WR3))
        else $error("header write outside relink");

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !in_ready)
        else $error("second beat taken while busy");

    a_res_after_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> state_reg == S_IDLE)
        else $error("result handed off without returning to idle");

endmodule
